FILE: design/gecp_pkg.sv
// Shared types and constants for the graph eccentricity block.
`default_nettype none
package gecp_pkg;

   localparam int DIST_W    = 32;
   localparam int NPV_W     = 31;
   localparam int VCNT_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_W     = 104;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_PATH      = 2'd1;

   localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;
   localparam logic [NPV_W-1:0]  NPV_RESET  = 31'h7FFF_FFFF;

   typedef struct packed {
      logic entry_accept;
      logic row_end;
      logic first_row;
      logic show;
      logic show_last;
   } ctrl_type;

endpackage
`default_nettype wire

FILE: design/gecp_ecc_store.sv
// Eccentricity store: one write port, one registered read port.
`default_nettype none
module gecp_ecc_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [gecp_pkg::DIST_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output      logic [gecp_pkg::DIST_W-1:0] rd_data
);
   import gecp_pkg::*;

   logic [DIST_W-1:0] mem [DEPTH];
   logic [DIST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/gecp_seq.sv
// Sequencer: matrix position counters, load phase and result walk.
`default_nettype none
module gecp_seq #(
   parameter int AW = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              restart,
   input  wire logic [AW-1:0]     last_pos,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic              rsp_tready,
   output      logic [AW-1:0]     wr_addr,
   output      logic [AW-1:0]     rd_addr,
   output      gecp_pkg::ctrl_type ctrl
);
   import gecp_pkg::*;

   localparam logic [1:0] S_LOAD = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SHOW = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] row_ff, row_in;
   logic [AW-1:0] emit_ff, emit_in;
   logic          col_last, row_last, emit_last;

   assign col_last  = (col_ff == last_pos);
   assign row_last  = (row_ff == last_pos);
   assign emit_last = (emit_ff == last_pos);

   assign req_tready        = (state_ff == S_LOAD);
   assign ctrl.entry_accept = req_tready && req_tvalid;
   assign ctrl.row_end      = ctrl.entry_accept && col_last;
   assign ctrl.first_row    = (row_ff == '0);
   assign ctrl.show         = (state_ff == S_SHOW);
   assign ctrl.show_last    = emit_last;
   assign wr_addr           = row_ff;
   assign rd_addr           = emit_ff;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      emit_in  = emit_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (ctrl.entry_accept) begin
               if (col_last) begin
                  col_in = '0;
                  if (row_last) begin
                     row_in   = '0;
                     emit_in  = '0;
                     state_in = S_READ;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         S_READ: begin
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_tready) begin
               if (emit_last) begin
                  state_in = S_LOAD;
               end else begin
                  emit_in  = emit_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         col_ff   <= '0;
         row_ff   <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         emit_ff  <= emit_in;
      end
   end

   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && ctrl.show))
      else $error("input and result phases overlap");

   a_matrix_done: assert property (@(posedge clock) disable iff (reset)
      (ctrl.row_end && row_last && !restart) |=> (state_ff == S_READ))
      else $error("result walk did not start after last entry");

   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      (ctrl.show && rsp_tready && emit_last) |=> req_tready)
      else $error("block not ready after final result");

endmodule
`default_nettype wire

FILE: design/graph_eccentricity_center_periphery.sv
// Top level: graph eccentricity, radius, diameter, center and periphery flags.
//
// Usage:
//   req_ channel carries one distance-matrix entry per item, row-major,
//   vertex_count rows of vertex_count entries. Entries equal to the no-path
//   value are ignored when taking a row maximum.
//   While loading, one entry is taken every cycle; signed compares update
//   the row maximum and, at row end, the running minimum and maximum of the
//   eccentricities; each eccentricity is written to an internal store.
//   After the final entry req_tready drops and the block walks the store,
//   presenting one rsp_ item per vertex in vertex order; each result passes
//   through a store read state, then a presentation state.
//   A stalled result simply holds until rsp_tready rises.
//   After the final result (tlast) the block is ready for the next matrix.
//   Reset (synchronous) restores vertex_count 64 and the largest no-path
//   value; a csr_ write to vertex_count or no-path restarts the loading matrix.
`default_nettype none
module graph_eccentricity_center_periphery #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [gecp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gecp_pkg::NPV_W-1:0]     csr_wdata,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [gecp_pkg::DIST_W-1:0]    req_tdata,  // distance
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // vertex_index, eccentricity, is_central, is_peripheral,
   // graph_radius, graph_diameter
   output      logic [gecp_pkg::RSP_W-1:0]     rsp_tdata,
   output      logic                           rsp_tlast  // last_vertex
);
   import gecp_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = ($clog2(MAX_VERTICES + 1) > VCNT_W) ?
                       $clog2(MAX_VERTICES + 1) : VCNT_W;

   logic [VCNT_W-1:0]        vcnt_ff;
   logic [NPV_W-1:0]         npv_ff;
   logic signed [DIST_W-1:0] row_max_ff;
   logic signed [DIST_W-1:0] min_ff;
   logic signed [DIST_W-1:0] max_ff;

   logic [CW-1:0]            vcnt_ext;
   logic [CW-1:0]            last_wide;
   logic [AW-1:0]            last_pos;
   logic                     restart;
   logic signed [DIST_W-1:0] entry_dist;
   logic signed [DIST_W-1:0] neg_npv;
   logic signed [DIST_W-1:0] new_max;
   logic signed [DIST_W-1:0] ecc;
   logic                     skip;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr;
   logic [DIST_W-1:0]        rd_data;
   ctrl_type                 ctrl;

   assign vcnt_ext = CW'(vcnt_ff);
   always_comb begin
      priority if (vcnt_ext == '0) begin
         last_wide = '0;
      end else if (vcnt_ext > CW'(MAX_VERTICES)) begin
         last_wide = CW'(MAX_VERTICES - 1);
      end else begin
         last_wide = vcnt_ext - 1'b1;
      end
   end
   assign last_pos = last_wide[AW-1:0];

   assign restart = csr_we &&
                    ((csr_index == CSR_VERTEX_COUNT) || (csr_index == CSR_NO_PATH));

   assign entry_dist = $signed(req_tdata);
   assign neg_npv    = -$signed({1'b0, npv_ff});
   assign skip       = (entry_dist == $signed({1'b0, npv_ff}));
   assign new_max    = (!skip && (entry_dist > row_max_ff)) ? entry_dist : row_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff    <= VCNT_RESET;
         npv_ff     <= NPV_RESET;
         row_max_ff <= -$signed({1'b0, NPV_RESET});
      end else if (restart) begin
         if (csr_index == CSR_VERTEX_COUNT) begin
            vcnt_ff    <= csr_wdata[VCNT_W-1:0];
            row_max_ff <= neg_npv;
         end else begin
            npv_ff     <= csr_wdata;
            row_max_ff <= -$signed({1'b0, csr_wdata});
         end
      end else if (ctrl.entry_accept) begin
         row_max_ff <= ctrl.row_end ? neg_npv : new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.row_end) begin
         if (ctrl.first_row || (new_max < min_ff)) begin
            min_ff <= new_max;
         end
         if (ctrl.first_row || (new_max > max_ff)) begin
            max_ff <= new_max;
         end
      end
   end

   gecp_seq #(
      .AW(AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .last_pos   (last_pos),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .ctrl       (ctrl)
   );

   gecp_ecc_store #(
      .DEPTH(MAX_VERTICES),
      .AW   (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctrl.row_end),
      .wr_addr (wr_addr),
      .wr_data (new_max),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ecc        = $signed(rd_data);
   assign rsp_tvalid = ctrl.show;
   assign rsp_tlast  = ctrl.show_last;
   assign rsp_tdata  = {max_ff, min_ff, (ecc == max_ff), (ecc == min_ff), ecc,
                        6'(rd_addr)};

endmodule
`default_nettype wire
